[hdl/tki_pkg.sv]
// Package for the bounded sorted top-k insert block.
// Holds field widths, operation codes and the payload and control structs.
// No dependencies.
package tki_pkg;

	localparam int KEY_W    = 32;
	localparam int POS_W    = 32;
	localparam int K_W      = 5;
	localparam int RIDX_W   = 4;
	localparam int FILL_W   = 5;
	localparam int DEF_MAX_NEIGHBORS = 16;
	localparam int K_RESET  = 16;

	localparam logic [KEY_W-1:0] EMPTY_KEY = '1;
	localparam logic [POS_W-1:0] EMPTY_POS = '1;

	typedef enum logic [1:0] {
		FN_CLEAR = 2'd0,
		FN_OFFER = 2'd1,
		FN_READ  = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [KEY_W-1:0]  cand_key;
		logic [POS_W-1:0]  cand_position;
		logic [RIDX_W-1:0] read_index;
	} cmd_t;

	typedef struct packed {
		logic              accepted;
		logic [KEY_W-1:0]  entry_key;
		logic [POS_W-1:0]  entry_position;
		logic [FILL_W-1:0] fill_count_out;
		logic [KEY_W-1:0]  kth_key;
	} rsp_t;

	// Broadcast control from the top level to every cell
	typedef struct packed {
		logic clear;   // empty every slot
		logic insert;  // accepted candidate: place or shift
		logic trunc;   // new k written: empty slots at rank k and beyond
	} cell_ctrl_t;

endpackage

[hdl/bounded_sorted_top_k_insert.sv]
// Top level of the bounded sorted top-k insert block: a row of list cells,
// the acceptance decision, fill count, k register and result port.
// Depends on tki_pkg and tki_cell.
//
// Usage:
//   Command channel: present cmd and raise start; the transaction is taken at
//   the rising edge where start is high and busy is low. busy stays low, so a
//   command may be issued in every cycle.
//   Operations: clear empties the list, offer inserts a (key, position) pair
//   in sorted place when its key is below the k-th key and not already held,
//   read reports one rank. Every command returns one result.
//   Result channel: done is high for exactly one cycle, the cycle after the
//   command was taken, and rsp holds the state after that command. The
//   receiver cannot stall; it must take rsp while done is high.
//   Throughput is one command per cycle: every cell compares against the
//   broadcast candidate and shifts in the same cycle.
//   Configuration: cfg_we with cfg_wdata writes k (0 acts as 1, values above
//   MAX_NEIGHBORS act as MAX_NEIGHBORS); slots at rank k and beyond empty.
//   Write it only while no result is pending.
//   Reset: all slots empty (all ones), fill count zero, k = 16 (capped at MAX_NEIGHBORS).
module bounded_sorted_top_k_insert #(
	parameter int MAX_NEIGHBORS = tki_pkg::DEF_MAX_NEIGHBORS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  tki_pkg::cmd_t            cmd,
	output logic                     done,
	output tki_pkg::rsp_t            rsp,
	input  logic                     cfg_we,
	input  logic [tki_pkg::K_W-1:0]  cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
	localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int K_RST = (tki_pkg::K_RESET > MAX_NEIGHBORS) ? MAX_NEIGHBORS
	                                                           : tki_pkg::K_RESET;

	logic [tki_pkg::KEY_W-1:0] key_a [MAX_NEIGHBORS];
	logic [tki_pkg::POS_W-1:0] pos_a [MAX_NEIGHBORS];
	logic [MAX_NEIGHBORS-1:0]  gt_v;
	logic [MAX_NEIGHBORS-1:0]  eq_v;

	logic [CNT_W-1:0]          k_q;
	logic [CNT_W-1:0]          k_new;
	logic [CNT_W-1:0]          k_lim;
	logic [CNT_W-1:0]          fill_q;
	logic [IDX_W-1:0]          kth_sel;
	logic [IDX_W-1:0]          rd_sel;
	logic                      take;
	logic                      acc;
	tki_pkg::cell_ctrl_t       ctrl;

	logic                      done_q;
	logic                      acc_q;
	logic [tki_pkg::RIDX_W-1:0] ridx_q;
	logic [1:0]                func_q;

	// Every command completes in the cycle it is taken
	assign busy = 1'b0;
	assign take = start && !busy;

	// Saturate the written k into 1..MAX_NEIGHBORS
	always_comb begin
		if (cfg_wdata == '0) begin
			k_new = CNT_W'(1);
		end else if (int'(cfg_wdata) > MAX_NEIGHBORS) begin
			k_new = CNT_W'(MAX_NEIGHBORS);
		end else begin
			k_new = CNT_W'(cfg_wdata);
		end
	end

	assign k_lim   = cfg_we ? k_new : k_q;
	assign kth_sel = IDX_W'(k_q - CNT_W'(1));

	// Accept when below the k-th key and no held key matches
	assign acc = take && (cmd.func == tki_pkg::FN_OFFER) && gt_v[kth_sel] && !(|eq_v);

	always_comb begin
		ctrl.clear  = take && (cmd.func == tki_pkg::FN_CLEAR);
		ctrl.insert = acc;
		ctrl.trunc  = cfg_we;
	end

	// Row of list cells, rank 0 first
	for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
		logic [tki_pkg::KEY_W-1:0] pk;
		logic [tki_pkg::POS_W-1:0] pp;
		logic                      pg;
		if (g == 0) begin : g_first
			assign pk = tki_pkg::EMPTY_KEY;
			assign pp = tki_pkg::EMPTY_POS;
			assign pg = 1'b0;
		end else begin : g_rest
			assign pk = key_a[g-1];
			assign pp = pos_a[g-1];
			assign pg = gt_v[g-1];
		end
		tki_cell #(
			.CELL_IDX (g),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cand_key      (cmd.cand_key),
			.cand_position (cmd.cand_position),
			.prev_key      (pk),
			.prev_position (pp),
			.prev_gt       (pg),
			.k_lim         (k_lim),
			.ctrl          (ctrl),
			.gt            (gt_v[g]),
			.eq            (eq_v[g]),
			.key           (key_a[g]),
			.position      (pos_a[g])
		);
	end

	// Hold k and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= CNT_W'(K_RST);
			fill_q <= '0;
		end else if (cfg_we) begin
			k_q <= k_new;
			if (fill_q > k_new) begin
				fill_q <= k_new;
			end
		end else if (ctrl.clear) begin
			fill_q <= '0;
		end else if (acc && (fill_q < k_q)) begin
			fill_q <= fill_q + CNT_W'(1);
		end
	end

	// Mark the result cycle and hold what the result needs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_q  <= acc;
			ridx_q <= cmd.read_index;
			func_q <= cmd.func;
		end
	end

	assign rd_sel = IDX_W'(ridx_q);
	assign done   = done_q;

	// Read the updated list for the result
	always_comb begin
		rsp.accepted = acc_q;
		if (int'(ridx_q) < MAX_NEIGHBORS) begin
			rsp.entry_key      = key_a[rd_sel];
			rsp.entry_position = pos_a[rd_sel];
		end else begin
			rsp.entry_key      = tki_pkg::EMPTY_KEY;
			rsp.entry_position = tki_pkg::EMPTY_POS;
		end
		rsp.fill_count_out = tki_pkg::FILL_W'(fill_q);
		rsp.kth_key        = key_a[kth_sel];
	end

	// Fill count never exceeds k
	a_fill_le_k: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= k_q)
		else $error("fill count above k");

	// The threshold slot stays empty until the list is full
	a_kth_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q < k_q) |-> (key_a[kth_sel] == tki_pkg::EMPTY_KEY))
		else $error("k-th slot occupied while list not full");

	// Each taken command yields one result in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> done)
		else $error("result strobe missing after command");

	// Only an offer can report accepted
	a_acc_offer: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.accepted) |-> (func_q == tki_pkg::FN_OFFER))
		else $error("accepted reported for a non-offer command");

	// An accepted offer grows the list unless it was full
	a_acc_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (fill_q < k_q)) |=> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("fill count did not grow on insert");

endmodule

[hdl/tki_cell.sv]
// One slot of the sorted list: holds a key and a position, compares against the
// broadcast candidate and takes the candidate or its lower neighbor's entry.
// Depends on tki_pkg.
module tki_cell #(
	parameter int CELL_IDX = 0,
	parameter int CNT_W    = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tki_pkg::KEY_W-1:0]  cand_key,
	input  logic [tki_pkg::POS_W-1:0]  cand_position,
	input  logic [tki_pkg::KEY_W-1:0]  prev_key,
	input  logic [tki_pkg::POS_W-1:0]  prev_position,
	input  logic                       prev_gt,
	input  logic [CNT_W-1:0]           k_lim,
	input  tki_pkg::cell_ctrl_t        ctrl,
	output logic                       gt,
	output logic                       eq,
	output logic [tki_pkg::KEY_W-1:0]  key,
	output logic [tki_pkg::POS_W-1:0]  position
);

	logic [tki_pkg::KEY_W-1:0] key_q;
	logic [tki_pkg::POS_W-1:0] pos_q;
	logic                      in_k;

	// Compare the held key against the candidate
	assign gt   = key_q > cand_key;
	assign eq   = key_q == cand_key;
	assign in_k = CNT_W'(CELL_IDX) < k_lim;

	assign key      = key_q;
	assign position = pos_q;

	// Empty, take the candidate, or shift in the neighbor's entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= tki_pkg::EMPTY_KEY;
			pos_q <= tki_pkg::EMPTY_POS;
		end else if (ctrl.clear || (ctrl.trunc && !in_k)) begin
			key_q <= tki_pkg::EMPTY_KEY;
			pos_q <= tki_pkg::EMPTY_POS;
		end else if (ctrl.insert && gt && in_k) begin
			if (prev_gt) begin
				key_q <= prev_key;
				pos_q <= prev_position;
			end else begin
				key_q <= cand_key;
				pos_q <= cand_position;
			end
		end
	end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for bounded_sorted_top_k_insert: directed table, then random phases.
// An in-bench model of the sorted top-k list predicts every result; depends on tki_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXN = tki_pkg::DEF_MAX_NEIGHBORS;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [1:0] FN_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	tki_pkg::cmd_t cmd;
	logic done;
	tki_pkg::rsp_t rsp;
	logic cfg_we;
	logic [tki_pkg::K_W-1:0] cfg_wdata;

	// One row of the directed plan: a k write or a command with an optional typed result
	typedef struct {
		bit                      is_cfg;
		logic [tki_pkg::K_W-1:0] k_val;
		tki_pkg::cmd_t           c;
		bit                      typed;
		tki_pkg::rsp_t           want;
	} step_row_t;

	// Model of the list
	logic [tki_pkg::KEY_W-1:0]  list_key [MAXN];
	logic [tki_pkg::POS_W-1:0]  list_pos [MAXN];
	int unsigned                list_fill;
	logic [tki_pkg::K_W-1:0]    k_setting;

	tki_pkg::rsp_t rsp_due[$];
	step_row_t     plan[$];
	int unsigned   mismatch_count;
	int unsigned   cycle_count;
	int unsigned   burst_left;

	bounded_sorted_top_k_insert #(
		.MAX_NEIGHBORS(MAXN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Saturate k to 1..MAXN
	function automatic int unsigned eff_k();
		int unsigned k;
		k = k_setting;
		if (k < 1) k = 1;
		if (k > MAXN) k = MAXN;
		return k;
	endfunction

	function automatic void empty_slots(int unsigned first);
		for (int unsigned i = first; i < MAXN; i++) begin
			list_key[i] = tki_pkg::EMPTY_KEY;
			list_pos[i] = tki_pkg::EMPTY_POS;
		end
	endfunction

	function automatic void list_reset();
		empty_slots(0);
		list_fill = 0;
		k_setting = tki_pkg::K_W'(tki_pkg::K_RESET);
	endfunction

	// Write k: drop entries at rank k and beyond
	function automatic void list_set_k(logic [tki_pkg::K_W-1:0] v);
		int unsigned k;
		k_setting = v;
		k = eff_k();
		if (list_fill > k) list_fill = k;
		empty_slots(k);
	endfunction

	// Insert in sorted place if below the threshold and not already held
	function automatic bit list_insert(logic [tki_pkg::KEY_W-1:0] key,
			logic [tki_pkg::POS_W-1:0] pos);
		int unsigned k;
		int unsigned held;
		int unsigned slot;
		int unsigned last;
		k = eff_k();
		held = (list_fill > k) ? k : list_fill;
		slot = 0;
		if (!(key < list_key[k-1])) return 1'b0;
		for (int unsigned i = 0; i < held; i++) begin
			if (list_key[i] == key) return 1'b0;
			if (list_key[i] < key) slot = i + 1;
		end
		last = (held == k) ? k - 1 : held;
		for (int unsigned i = last; i > slot; i--) begin
			list_key[i] = list_key[i-1];
			list_pos[i] = list_pos[i-1];
		end
		list_key[slot] = key;
		list_pos[slot] = pos;
		if (held < k) list_fill = held + 1;
		return 1'b1;
	endfunction

	// Advance the model by one command and return the result it reports
	function automatic tki_pkg::rsp_t topk_apply(tki_pkg::cmd_t c);
		tki_pkg::rsp_t r;
		bit acc;
		acc = 1'b0;
		if (c.func == tki_pkg::FN_CLEAR) begin
			empty_slots(0);
			list_fill = 0;
		end else if (c.func == tki_pkg::FN_OFFER) begin
			acc = list_insert(c.cand_key, c.cand_position);
		end
		r.accepted = acc;
		if (int'(c.read_index) < MAXN) begin
			r.entry_key = list_key[c.read_index];
			r.entry_position = list_pos[c.read_index];
		end else begin
			r.entry_key = tki_pkg::EMPTY_KEY;
			r.entry_position = tki_pkg::EMPTY_POS;
		end
		r.fill_count_out = tki_pkg::FILL_W'(list_fill);
		r.kth_key = list_key[eff_k()-1];
		return r;
	endfunction

	function automatic step_row_t op_row(logic [1:0] f, logic [tki_pkg::KEY_W-1:0] key,
			logic [tki_pkg::POS_W-1:0] pos, logic [tki_pkg::RIDX_W-1:0] idx, bit typed,
			tki_pkg::rsp_t want);
		step_row_t row;
		row.is_cfg = 1'b0;
		row.k_val = '0;
		row.c = tki_pkg::cmd_t'{f, key, pos, idx};
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic step_row_t k_row(logic [tki_pkg::K_W-1:0] v);
		step_row_t row;
		row.is_cfg = 1'b1;
		row.k_val = v;
		row.c = '0;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic tki_pkg::rsp_t mk_rsp(logic acc, logic [tki_pkg::KEY_W-1:0] key,
			logic [tki_pkg::POS_W-1:0] pos, logic [tki_pkg::FILL_W-1:0] fill,
			logic [tki_pkg::KEY_W-1:0] kth);
		return tki_pkg::rsp_t'{acc, key, pos, fill, kth};
	endfunction

	// Random key: near zero for duplicates, full range, near all ones, or at the threshold
	function automatic logic [tki_pkg::KEY_W-1:0] pick_key();
		int unsigned sel;
		logic [tki_pkg::KEY_W-1:0] kth;
		sel = $urandom_range(0, 99);
		kth = list_key[eff_k()-1];
		if (sel < 40) return tki_pkg::KEY_W'($urandom_range(0, 63));
		if (sel < 70) return tki_pkg::KEY_W'($urandom);
		if (sel < 85) return tki_pkg::EMPTY_KEY - tki_pkg::KEY_W'($urandom_range(0, 15));
		if (kth == '0) return kth;
		return kth - tki_pkg::KEY_W'($urandom_range(0, 1));
	endfunction

	// Hold start low for a random gap after a transaction, with bursts of no gap
	task automatic idle_after();
		int unsigned sel;
		int unsigned gap;
		gap = 0;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 3) burst_left = $urandom_range(10, 40);
			else if (sel < 55) gap = 0;
			else if (sel < 88) gap = $urandom_range(1, 3);
			else if (sel < 97) gap = $urandom_range(4, 10);
			else gap = $urandom_range(11, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Present a command, wait for the handshake, then record the expected result
	task automatic issue(tki_pkg::cmd_t c, bit typed, tki_pkg::rsp_t want);
		tki_pkg::rsp_t r;
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		r = topk_apply(c);
		rsp_due.push_back(typed ? want : r);
		idle_after();
	endtask

	// Stop issuing and wait until every result is back
	task automatic quiesce();
		start <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_k(logic [tki_pkg::K_W-1:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		list_set_k(v);
	endtask

	task automatic random_cmd();
		tki_pkg::cmd_t c;
		int unsigned sel;
		logic [tki_pkg::POS_W-1:0] pos;
		sel = $urandom_range(0, 99);
		if (sel < 4) c.func = tki_pkg::FN_CLEAR;
		else if (sel < 70) c.func = tki_pkg::FN_OFFER;
		else if (sel < 92) c.func = tki_pkg::FN_READ;
		else c.func = FN_SPARE;
		pos = $urandom;
		if (pos == tki_pkg::EMPTY_POS) pos = pos - 1;
		c.cand_key = pick_key();
		c.cand_position = pos;
		c.read_index = tki_pkg::RIDX_W'($urandom_range(0, 15));
		issue(c, 1'b0, '0);
	endtask

	function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
		if (a !== e) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, e, a);
			mismatch_count++;
		end
	endfunction

	// Compare each result against the oldest expectation
	always @(posedge clk) begin
		tki_pkg::rsp_t want;
		if (done === 1'b1) begin
			if (rsp_due.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, rsp);
				mismatch_count++;
			end else begin
				want = rsp_due.pop_front();
				check_field("accepted", 32'(want.accepted), 32'(rsp.accepted));
				check_field("entry_key", want.entry_key, rsp.entry_key);
				check_field("entry_position", want.entry_position, rsp.entry_position);
				check_field("fill_count_out", 32'(want.fill_count_out),
					32'(rsp.fill_count_out));
				check_field("kth_key", want.kth_key, rsp.kth_key);
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [tki_pkg::K_W-1:0] phase_k [8];
		mismatch_count = 0;
		cycle_count = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		list_reset();

		// Directed plan: empty list, extremes, duplicates, clear, shrinking and out-of-range k
		plan.push_back(op_row(tki_pkg::FN_READ, '0, '0, 4'd0, 1'b1,
			mk_rsp(1'b0, tki_pkg::EMPTY_KEY, tki_pkg::EMPTY_POS, 5'd0, tki_pkg::EMPTY_KEY)));
		plan.push_back(op_row(tki_pkg::FN_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 4'd15, 1'b1,
			mk_rsp(1'b0, tki_pkg::EMPTY_KEY, tki_pkg::EMPTY_POS, 5'd0, tki_pkg::EMPTY_KEY)));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'h0, 32'hFFFF_FFFE, 4'd0, 1'b1,
			mk_rsp(1'b1, 32'h0, 32'hFFFF_FFFE, 5'd1, tki_pkg::EMPTY_KEY)));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'hFFFF_FFFF, 32'h1, 4'd0, 1'b1,
			mk_rsp(1'b0, 32'h0, 32'hFFFF_FFFE, 5'd1, tki_pkg::EMPTY_KEY)));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'h0, 32'h5, 4'd0, 1'b1,
			mk_rsp(1'b0, 32'h0, 32'hFFFF_FFFE, 5'd1, tki_pkg::EMPTY_KEY)));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'hFFFF_FFFE, 32'h0, 4'd1, 1'b1,
			mk_rsp(1'b1, 32'hFFFF_FFFE, 32'h0, 5'd2, tki_pkg::EMPTY_KEY)));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'd100, 32'd7, 4'd1, 1'b0, '0));
		plan.push_back(op_row(FN_SPARE, 32'd3, 32'd3, 4'd2, 1'b0, '0));
		plan.push_back(op_row(tki_pkg::FN_READ, 32'd1, 32'd1, 4'd1, 1'b0, '0));
		plan.push_back(op_row(tki_pkg::FN_CLEAR, 32'd55, 32'd55, 4'd0, 1'b1,
			mk_rsp(1'b0, tki_pkg::EMPTY_KEY, tki_pkg::EMPTY_POS, 5'd0, tki_pkg::EMPTY_KEY)));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'd50, 32'd1, 4'd0, 1'b0, '0));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'd20, 32'd2, 4'd0, 1'b0, '0));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'd30, 32'd3, 4'd2, 1'b0, '0));
		plan.push_back(k_row(5'd2));
		plan.push_back(op_row(tki_pkg::FN_READ, '0, '0, 4'd2, 1'b0, '0));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'd10, 32'd4, 4'd0, 1'b0, '0));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'd40, 32'd8, 4'd1, 1'b0, '0));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'd20, 32'd9, 4'd1, 1'b0, '0));
		plan.push_back(k_row(5'd0));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'd5, 32'd9, 4'd0, 1'b0, '0));
		plan.push_back(op_row(tki_pkg::FN_OFFER, 32'd7, 32'd6, 4'd0, 1'b0, '0));
		plan.push_back(k_row(5'd31));
		plan.push_back(op_row(tki_pkg::FN_READ, '0, '0, 4'd15, 1'b0, '0));
		plan.push_back(k_row(5'd16));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed plan
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				quiesce();
				write_k(plan[i].k_val);
			end else begin
				issue(plan[i].c, plan[i].typed, plan[i].want);
			end
		end

		// Random phases, each under its own k
		phase_k = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd5, 5'd16, 5'd8};
		phase_k[6] = tki_pkg::K_W'($urandom_range(1, 16));
		foreach (phase_k[p]) begin
			quiesce();
			write_k(phase_k[p]);
			repeat (100) random_cmd();
		end

		quiesce();
		repeat (5) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
